// ----- rtl/mcol_pkg.sv -----
// Package: beat types, internal float format and rounding helpers for the column transform.
`timescale 1ns / 1ps

package mcol_pkg;

    localparam int ROWS      = 4;
    localparam int CFG_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;
    localparam int MUL_LAT   = 3;
    localparam int ADD_LAT   = 3;
    localparam int PIPE_LAT  = MUL_LAT + 3 * ADD_LAT;

    localparam logic [31:0] QNAN    = 32'h7FC0_0000;
    localparam logic [33:0] INF_LIM = 34'h0_7F80_0000;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_REGS] = '{
        64'h0000_0000_3F80_0000,
        64'h0000_0000_0000_0000,
        64'h3F80_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_3F80_0000,
        64'h0000_0000_0000_0000,
        64'h3F80_0000_0000_0000
    };

    typedef struct packed {
        logic [31:0] right_row0;
        logic [31:0] right_row1;
        logic [31:0] right_row2;
        logic [31:0] right_row3;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] product_row0;
        logic [31:0] product_row1;
        logic [31:0] product_row2;
        logic [31:0] product_row3;
    } out_beat_t;

    // Unrounded value: (-1)^sgn * man * 2^(exp - 127 - 51), or a fixed special result
    typedef struct packed {
        logic               sgn;
        logic               spec;
        logic [31:0]        spec_bits;
        logic signed [11:0] exp;
        logic [51:0]        man;
    } fnum_t;

    // Count leading zeros of a 52-bit mantissa
    function automatic logic [5:0] lzc52(input logic [51:0] m);
        logic [5:0] n;
        logic       found;
        n     = 6'd52;
        found = 1'b0;
        for (int i = 51; i >= 0; i--)
        begin
            if (!found && m[i])
            begin
                n     = 6'(51 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Move the leading one to bit 51, or denormalize so exp stays at 1
    function automatic fnum_t fnorm(input fnum_t x);
        fnum_t              y;
        logic [5:0]         lz;
        logic [5:0]         sh;
        logic signed [11:0] ex;
        logic signed [11:0] lzs;
        logic signed [11:0] rem;
        logic [63:0]        wide;
        logic [63:0]        mask;
        y    = x;
        lz   = lzc52(x.man);
        ex   = x.exp;
        lzs  = $signed({6'd0, lz});
        rem  = 12'sd1 - ex;
        wide = {12'd0, x.man};
        sh   = 6'd0;
        mask = 64'd0;
        if (x.spec || x.man == 52'd0)
        begin
            y = x;
        end
        else if (ex - lzs >= 12'sd1)
        begin
            y.man = x.man << lz;
            y.exp = ex - lzs;
        end
        else if (ex >= 12'sd1)
        begin
            sh    = 6'(ex - 12'sd1);
            y.man = x.man << sh;
            y.exp = 12'sd1;
        end
        else
        begin
            sh    = (rem > 12'sd63) ? 6'd63 : rem[5:0];
            mask  = (64'd1 << sh) - 64'd1;
            y.man = 52'(wide >> sh) | {51'd0, |(wide & mask)};
            y.exp = 12'sd1;
        end
        return y;
    endfunction

    // Round to nearest even and pack into binary32
    function automatic logic [31:0] fround(input fnum_t x);
        logic [23:0]        m24;
        logic               inc;
        logic signed [11:0] ex;
        logic [11:0]        em1;
        logic [33:0]        sum;
        logic [31:0]        r;
        m24 = x.man[51:28];
        inc = x.man[27] & ((|x.man[26:0]) | m24[0]);
        ex  = x.exp;
        em1 = 12'(ex - 12'sd1);
        sum = ({22'd0, em1} << 23) + {10'd0, m24} + {33'd0, inc};
        if (x.spec)
            r = x.spec_bits;
        else if (x.man == 52'd0)
            r = {x.sgn, 31'd0};
        else if (sum >= INF_LIM)
            r = {x.sgn, 8'hFF, 23'd0};
        else
            r = {x.sgn, sum[30:0]};
        return r;
    endfunction

endpackage

// ----- rtl/matrix_column_transform_4x4.sv -----
// Top level: left matrix registers, four row lanes and the valid pipeline.
`timescale 1ns / 1ps

// Multiplies the 4x4 binary32 left matrix held in eight 64-bit registers by one
// column of a right matrix per beat and returns the matching product column.
// Input channel in_valid/in_stall/in_data carries a column (rows 0..3); output
// channel out_valid/out_stall/out_data carries the product column.
// Each row is ((p0+p1)+p2)+p3 with every product and sum rounded to nearest even;
// any NaN result comes out as 0x7FC00000.
// From acceptance to out_valid a column passes through the multipliers (multiply,
// normalize, round) and then through each of the three chained adders.
// Throughput is one column per cycle while no stalled result holds the pipeline;
// all sixteen multipliers and twelve adders are fully pipelined.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the identity matrix.
// Write registers through cfg_we/cfg_index/cfg_data only while the block is
// empty; indexes 8 and up are ignored.

module matrix_column_transform_4x4
    import mcol_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_beat_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]    cfg_reg [CFG_REGS];
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;
    logic                adv;
    logic [31:0]         col  [ROWS];
    logic [31:0]         rres [ROWS];

    // Hold the pipeline while a finished beat is stalled
    assign adv      = !(vld_reg[PIPE_LAT-1] && out_stall);
    assign in_stall = !adv;

    // Left matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REGS; i++)
                cfg_reg[i] <= CFG_RESET[i];
        end
        else if (cfg_we && !cfg_index[CFG_IDX_W-1])
        begin
            cfg_reg[cfg_index[CFG_IDX_W-2:0]] <= cfg_data;
        end
    end

    // Valid bits travel with the data
    assign vld_next = {vld_reg[PIPE_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    assign col[0] = in_data.right_row0;
    assign col[1] = in_data.right_row1;
    assign col[2] = in_data.right_row2;
    assign col[3] = in_data.right_row3;

    // One lane per result row
    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        logic [31:0] lrow [ROWS];
        for (genvar k = 0; k < ROWS; k++)
        begin : g_elem
            assign lrow[k] = cfg_reg[2*k + r/2][32*(r%2) +: 32];
        end

        mcol_row u_row (
            .clk  (clk),
            .en   (adv),
            .lrow (lrow),
            .col  (col),
            .res  (rres[r])
        );
    end

    assign out_valid             = vld_reg[PIPE_LAT-1];
    assign out_data.product_row0 = rres[0];
    assign out_data.product_row1 = rres[1];
    assign out_data.product_row2 = rres[2];
    assign out_data.product_row3 = rres[3];

    // A held pipeline keeps its occupancy
    a_hold_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid pipeline moved while held");

    // An accepted beat enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_valid |=> vld_reg[0])
        else $error("accepted beat lost at entry");

    // An advancing pipeline shifts valid bits one stage
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> vld_reg[PIPE_LAT-1:1] == $past(vld_reg[PIPE_LAT-2:0]))
        else $error("valid bits did not shift");

endmodule

// ----- rtl/mcol_fmul.sv -----
// Three-stage binary32 multiplier: multiply, normalize, round.
`timescale 1ns / 1ps

module mcol_fmul
    import mcol_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] res
);

    fnum_t       s1_next;
    fnum_t       s1_reg;
    fnum_t       s2_reg;
    logic [31:0] res_reg;

    logic [7:0]  ea, eb, ua, ub;
    logic [23:0] ma, mb;
    logic [47:0] mprod;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;

    // Unpack operands, flag specials and form the exact product
    always_comb
    begin
        ua     = a[30:23];
        ub     = b[30:23];
        ea     = (ua == 8'd0) ? 8'd1 : ua;
        eb     = (ub == 8'd0) ? 8'd1 : ub;
        ma     = {ua != 8'd0, a[22:0]};
        mb     = {ub != 8'd0, b[22:0]};
        mprod  = {24'd0, ma} * {24'd0, mb};
        nan_a  = (ua == 8'hFF) && (a[22:0] != 23'd0);
        nan_b  = (ub == 8'hFF) && (b[22:0] != 23'd0);
        inf_a  = (ua == 8'hFF) && (a[22:0] == 23'd0);
        inf_b  = (ub == 8'hFF) && (b[22:0] == 23'd0);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        sgn    = a[31] ^ b[31];

        s1_next.sgn       = sgn;
        s1_next.exp       = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
        s1_next.man       = {mprod, 4'd0};
        s1_next.spec      = 1'b0;
        s1_next.spec_bits = 32'd0;
        if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b))
        begin
            s1_next.spec      = 1'b1;
            s1_next.spec_bits = QNAN;
        end
        else if (inf_a || inf_b)
        begin
            s1_next.spec      = 1'b1;
            s1_next.spec_bits = {sgn, 8'hFF, 23'd0};
        end
    end

    // Advance the three stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= fnorm(s1_reg);
            res_reg <= fround(s2_reg);
        end
    end

    assign res = res_reg;

endmodule

// ----- rtl/mcol_fadd.sv -----
// Three-stage binary32 adder: align and add, normalize, round.
`timescale 1ns / 1ps

module mcol_fadd
    import mcol_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] res
);

    fnum_t       s1_next;
    fnum_t       s1_reg;
    fnum_t       s2_reg;
    logic [31:0] res_reg;

    logic [7:0]  ua, ub, ea, eb, el, es, d;
    logic [23:0] ma, mb, ml, ms;
    logic        sl, ss, swap;
    logic        nan_a, nan_b, inf_a, inf_b;
    logic [5:0]  sh;
    logic [63:0] big, sml, mask, aligned, sum;

    // Order operands by magnitude, align the smaller one and add
    always_comb
    begin
        ua    = a[30:23];
        ub    = b[30:23];
        ea    = (ua == 8'd0) ? 8'd1 : ua;
        eb    = (ub == 8'd0) ? 8'd1 : ub;
        ma    = {ua != 8'd0, a[22:0]};
        mb    = {ub != 8'd0, b[22:0]};
        nan_a = (ua == 8'hFF) && (a[22:0] != 23'd0);
        nan_b = (ub == 8'hFF) && (b[22:0] != 23'd0);
        inf_a = (ua == 8'hFF) && (a[22:0] == 23'd0);
        inf_b = (ub == 8'hFF) && (b[22:0] == 23'd0);

        swap  = {ea, ma} < {eb, mb};
        el    = swap ? eb : ea;
        es    = swap ? ea : eb;
        ml    = swap ? mb : ma;
        ms    = swap ? ma : mb;
        sl    = swap ? b[31] : a[31];
        ss    = swap ? a[31] : b[31];

        d       = el - es;
        sh      = (d > 8'd63) ? 6'd63 : d[5:0];
        big     = {14'd0, ml, 26'd0};
        sml     = {14'd0, ms, 26'd0};
        mask    = (64'd1 << sh) - 64'd1;
        aligned = (sml >> sh) | {63'd0, |(sml & mask)};
        sum     = (sl == ss) ? (big + aligned) : (big - aligned);

        s1_next.sgn       = (sum == 64'd0) ? (a[31] & b[31]) : sl;
        s1_next.exp       = $signed({4'd0, el}) + 12'sd2;
        s1_next.man       = sum[51:0];
        s1_next.spec      = 1'b0;
        s1_next.spec_bits = 32'd0;
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31])))
        begin
            s1_next.spec      = 1'b1;
            s1_next.spec_bits = QNAN;
        end
        else if (inf_a)
        begin
            s1_next.spec      = 1'b1;
            s1_next.spec_bits = a;
        end
        else if (inf_b)
        begin
            s1_next.spec      = 1'b1;
            s1_next.spec_bits = b;
        end
    end

    // Advance the three stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= fnorm(s1_reg);
            res_reg <= fround(s2_reg);
        end
    end

    assign res = res_reg;

endmodule

// ----- rtl/mcol_row.sv -----
// One result row: four multipliers feeding a chain of three adders.
`timescale 1ns / 1ps

module mcol_row
    import mcol_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] lrow [ROWS],
    input  logic [31:0] col  [ROWS],
    output logic [31:0] res
);

    logic [31:0] prod [ROWS];
    logic [31:0] p2_dly_reg [ADD_LAT];
    logic [31:0] p3_dly_reg [2*ADD_LAT];
    logic [31:0] sum01, sum012;

    // Products of this row, all in parallel
    for (genvar k = 0; k < ROWS; k++)
    begin : g_mul
        mcol_fmul u_mul (
            .clk (clk),
            .en  (en),
            .a   (lrow[k]),
            .b   (col[k]),
            .res (prod[k])
        );
    end

    // Hold late products until their adder is reached
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_dly_reg[0] <= prod[2];
            for (int i = 1; i < ADD_LAT; i++)
                p2_dly_reg[i] <= p2_dly_reg[i-1];
            p3_dly_reg[0] <= prod[3];
            for (int i = 1; i < 2*ADD_LAT; i++)
                p3_dly_reg[i] <= p3_dly_reg[i-1];
        end
    end

    // Accumulate left to right
    mcol_fadd u_add0 (
        .clk (clk),
        .en  (en),
        .a   (prod[0]),
        .b   (prod[1]),
        .res (sum01)
    );

    mcol_fadd u_add1 (
        .clk (clk),
        .en  (en),
        .a   (sum01),
        .b   (p2_dly_reg[ADD_LAT-1]),
        .res (sum012)
    );

    mcol_fadd u_add2 (
        .clk (clk),
        .en  (en),
        .a   (sum012),
        .b   (p3_dly_reg[2*ADD_LAT-1]),
        .res (res)
    );

endmodule
